### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain condition checked at every rising clock edge outside reset
`define TDPT_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Same-cycle implication
`define TDPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication
`define TDPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### rtl/core/tdpt_pkg.sv
// Package for the trial division prime test unit: constants and sequencer states.
// No dependencies.
package tdpt_pkg;

    // Default width of the value under test
    localparam int VALUE_BITS_DEF = 16;
    // Fixed width of the candidate and number words
    localparam int NUMBER_BITS    = 16;
    // First trial divisor
    localparam int FIRST_DIVISOR  = 2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

### rtl/core/trial_division_prime_test_unit.sv
// Trial division prime test unit: one shared compare/subtract unit under a small sequencer.
// Depends on tdpt_pkg and assert_macros.svh.

// Takes one 16-bit candidate word, masked to VALUE_BITS, and returns it with a prime flag.
// Divisors d = 2, 3, ... are tried while d*d <= n. For each divisor the bound is checked in
// S_CHECK, then a restoring remainder loop walks the VALUE_BITS bits of n, one per cycle,
// through a single compare/subtract unit. The running square is kept incrementally, so
// no multiplier is used; 0, 1, 2 and 3 are settled in S_CHECK without a division. The
// input side is ready only while the sequencer is idle; a finished word sits in an output
// register and the next candidate may be accepted while it waits.
`include "assert_macros.svh"

module trial_division_prime_test_unit #(
    parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tdpt_pkg::NUMBER_BITS-1:0] i_candidate,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tdpt_pkg::NUMBER_BITS-1:0] o_number,
    output logic                             o_is_prime
);
    import tdpt_pkg::*;

    // Divisor width: the last divisor tried is at most 2^ceil(VALUE_BITS/2)
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = 2 * DIV_BITS;
    localparam int BIT_IDX  = $clog2(VALUE_BITS);

    t_state                  r_state,     n_state;
    logic [VALUE_BITS-1:0]   r_n,         n_n;
    logic [NUMBER_BITS-1:0]  r_num,       n_num;
    logic [DIV_BITS-1:0]     r_div,       n_div;
    logic [SQ_BITS-1:0]      r_square,    n_square;
    logic [DIV_BITS-1:0]     r_rem,       n_rem;
    logic [BIT_IDX-1:0]      r_bit,       n_bit;
    logic                    r_verdict,   n_verdict;
    logic                    r_out_valid, n_out_valid;
    logic [NUMBER_BITS-1:0]  r_out_num,   n_out_num;
    logic                    r_out_prime, n_out_prime;

    logic [31:0]             cand_ext;
    logic [VALUE_BITS-1:0]   cand_masked;
    logic [DIV_BITS:0]       rem_shift;
    logic                    rem_ge;
    logic [DIV_BITS-1:0]     rem_new;

    // Candidate masked to the tested width
    assign cand_ext    = 32'(i_candidate);
    assign cand_masked = cand_ext[VALUE_BITS-1:0];

    // Shared remainder unit: shift in the next bit of n, subtract the divisor if it fits
    assign rem_shift = {r_rem, r_n[r_bit]};
    assign rem_ge    = rem_shift >= {1'b0, r_div};
    assign rem_new   = rem_ge ? DIV_BITS'(rem_shift - {1'b0, r_div})
                              : rem_shift[DIV_BITS-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_number    = r_out_num;
    assign o_is_prime  = r_out_prime;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_num       <= n_num;
        r_div       <= n_div;
        r_square    <= n_square;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_verdict   <= n_verdict;
        r_out_num   <= n_out_num;
        r_out_prime <= n_out_prime;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_num       = r_num;
        n_div       = r_div;
        n_square    = r_square;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_verdict   = r_verdict;
        n_out_num   = r_out_num;
        n_out_prime = r_out_prime;
        // output word leaves when taken
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_n      = cand_masked;
                    n_num    = NUMBER_BITS'(32'(cand_masked));
                    n_div    = DIV_BITS'(FIRST_DIVISOR);
                    n_square = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_n < VALUE_BITS'(FIRST_DIVISOR)) begin
                    // zero and one are not prime
                    n_verdict = 1'b0;
                    n_state   = S_FINISH;
                end else if (r_square > SQ_BITS'(r_n)) begin
                    // no divisor left under the square-root bound
                    n_verdict = 1'b1;
                    n_state   = S_FINISH;
                end else begin
                    n_rem   = '0;
                    n_bit   = BIT_IDX'(VALUE_BITS - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = rem_new;
                if (r_bit == '0) begin
                    if (rem_new == '0) begin
                        n_verdict = 1'b0;
                        n_state   = S_FINISH;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        n_square = r_square + SQ_BITS'({r_div, 1'b1});
                        n_div    = r_div + 1'b1;
                        n_state  = S_CHECK;
                    end
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_num;
                    n_out_prime = r_verdict;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Checks
    `TDPT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_CHECK)
    `TDPT_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_div)
    `TDPT_ASSERT_IMPL(a_div_in_bound, i_clk, i_rst_n, r_state == S_DIV, r_square <= SQ_BITS'(r_n))
    `TDPT_ASSERT_IMPL(a_prime_ge_two, i_clk, i_rst_n, o_out_valid && o_is_prime, o_number >= 16'd2)

endmodule
